// ===== rtl/core/jsu_pkg.sv =====
// Package: shared types, codes and constants of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  localparam int MAX_RESULTS   = 3;
  localparam int QUEUE_DEPTH_D = 8;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_EXPECT_QUOTE = 2'd0;
  localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd1;
  localparam logic [1:0] ERR_SHORT_HEX    = 2'd2;
  localparam logic [1:0] ERR_UNTERMINATED = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } jsu_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last_of_run;
  } jsu_result_t;

  // Up to three results from one item, written to the queue together.
  typedef struct packed {
    logic [1:0]                        n;
    jsu_result_t [MAX_RESULTS-1:0]     res;
  } jsu_push_t;

  typedef struct packed {
    jsu_phase_t phase;
  } jsu_dec_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/jsu_chan_if.sv =====
// Interfaces: input byte channel and result channel.
`default_nettype none
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jsu_decoder.sv =====
// Decoder: parse state and per-item decode into up to three results.
`default_nettype none
module jsu_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     op,
  input  logic [7:0]               data_byte,
  output jsu_pkg::jsu_push_t       push,
  output jsu_pkg::jsu_dec_status_t status
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  jsu_phase_t  phase_r, phase_nxt;
  logic [15:0] hex_value_r, hex_value_nxt;
  logic [2:0]  hex_count_r, hex_count_nxt;
  logic        hex_stopped_r, hex_stopped_nxt;

  logic        digit_ok;
  logic [3:0]  digit;
  logic [15:0] code;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      digit = data_byte[3:0];
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      digit = data_byte[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    hex_value_nxt   = hex_value_r;
    hex_count_nxt   = hex_count_r;
    hex_stopped_nxt = hex_stopped_r;
    push            = '0;
    code            = 16'd0;

    if (op == OP_END) begin
      if (phase_r == PH_HEX) begin
        push.n                 = 2'd1;
        push.res[0].kind       = KIND_ERROR;
        push.res[0].error_code = ERR_SHORT_HEX;
      end else if (phase_r != PH_IDLE) begin
        push.n                 = 2'd1;
        push.res[0].kind       = KIND_ERROR;
        push.res[0].error_code = ERR_UNTERMINATED;
      end
      phase_nxt       = PH_IDLE;
      hex_value_nxt   = 16'd0;
      hex_count_nxt   = 3'd0;
      hex_stopped_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (data_byte == CH_QUOTE) begin
            phase_nxt = PH_STR;
          end else begin
            push.n                 = 2'd1;
            push.res[0].kind       = KIND_ERROR;
            push.res[0].error_code = ERR_EXPECT_QUOTE;
          end
        end
        PH_STR: begin
          if (data_byte == CH_QUOTE) begin
            push.n           = 2'd1;
            push.res[0].kind = KIND_DONE;
            phase_nxt        = PH_IDLE;
          end else if (data_byte == CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            push.n               = 2'd1;
            push.res[0].kind     = KIND_BYTE;
            push.res[0].out_byte = data_byte;
          end
        end
        PH_ESC: begin
          push.n           = 2'd1;
          push.res[0].kind = KIND_BYTE;
          phase_nxt        = PH_STR;
          case (data_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push.res[0].out_byte = data_byte;
            CH_B: push.res[0].out_byte = 8'h08;
            CH_F: push.res[0].out_byte = 8'h0c;
            CH_N: push.res[0].out_byte = 8'h0a;
            CH_R: push.res[0].out_byte = 8'h0d;
            CH_T: push.res[0].out_byte = 8'h09;
            CH_U: begin
              push.n          = 2'd0;
              phase_nxt       = PH_HEX;
              hex_value_nxt   = 16'd0;
              hex_count_nxt   = 3'd0;
              hex_stopped_nxt = 1'b0;
            end
            default: begin
              push.res[0].kind       = KIND_ERROR;
              push.res[0].error_code = ERR_BAD_ESCAPE;
              phase_nxt              = PH_IDLE;
            end
          endcase
        end
        PH_HEX: begin
          if (!hex_stopped_r && digit_ok) begin
            hex_value_nxt = {hex_value_r[11:0], digit};
          end else begin
            hex_stopped_nxt = 1'b1;
          end
          hex_count_nxt = hex_count_r + 3'd1;
          code          = hex_value_nxt;
          if (hex_count_nxt >= 3'd4) begin
            push.res[0].kind = KIND_BYTE;
            push.res[1].kind = KIND_BYTE;
            push.res[2].kind = KIND_BYTE;
            if (code < 16'h0080) begin
              push.n               = 2'd1;
              push.res[0].out_byte = code[7:0];
            end else if (code < 16'h0800) begin
              push.n               = 2'd2;
              push.res[0].out_byte = {3'b110, code[10:6]};
              push.res[1].out_byte = {2'b10, code[5:0]};
            end else begin
              push.n               = 2'd3;
              push.res[0].out_byte = {4'b1110, code[15:12]};
              push.res[1].out_byte = {2'b10, code[11:6]};
              push.res[2].out_byte = {2'b10, code[5:0]};
            end
            phase_nxt       = PH_STR;
            hex_value_nxt   = 16'd0;
            hex_count_nxt   = 3'd0;
            hex_stopped_nxt = 1'b0;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // Flag the final result of this item.
    if (push.n != 2'd0) begin
      push.res[push.n - 2'd1].last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      hex_value_r   <= 16'd0;
      hex_count_r   <= 3'd0;
      hex_stopped_r <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      hex_value_r   <= hex_value_nxt;
      hex_count_r   <= hex_count_nxt;
      hex_stopped_r <= hex_stopped_nxt;
    end
  end

  assign status.phase = phase_r;

endmodule
`default_nettype wire

// ===== rtl/core/jsu_result_queue.sv =====
// Result queue: takes up to three results a cycle, gives one a cycle while the head is taken.
`default_nettype none
module jsu_result_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_en,
  input  jsu_pkg::jsu_push_t   push,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 head_ready,
  output jsu_pkg::jsu_result_t head
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_result_t             mem_r [DEPTH];
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [PTR_W-1:0]        wr_idx [MAX_RESULTS];
  logic                    pop;
  logic [1:0]              n_in;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [1:0] inc);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + (PTR_W+1)'(inc);
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign pop        = head_valid && head_ready;
  assign n_in       = push_en ? push.n : 2'd0;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room       = (count_r <= CNT_W'(DEPTH - MAX_RESULTS));

  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      wr_idx[i] = wrap_add(wr_ptr_r, 2'(i));
    end
    wr_ptr_nxt = wrap_add(wr_ptr_r, n_in);
    rd_ptr_nxt = pop ? wrap_add(rd_ptr_r, 2'd1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(n_in) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < n_in) begin
        mem_r[wr_idx[i]] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/json_string_unescaper_core.sv =====
// Top level: JSON string unescaper, raw quoted-string bytes in, UTF-8 bytes out.
`default_nettype none
// Feed the bytes of a quoted JSON string, opening quote first, one item per
// byte (op 0), or op 1 to mark end of text. Plain bytes pass through, the
// simple backslash escapes are decoded and a \uXXXX escape becomes one to
// three UTF-8 bytes (no surrogate pairing); the closing quote gives a done
// result and any error puts the block back to waiting for an opening quote.
// Each item is decoded in the cycle it is accepted and its results are
// written to the result queue in that cycle; results leave the queue
// at one per cycle while the sink takes them. Input ready is high while
// the queue has room for three results, which gives one item per cycle
// whenever the sink keeps up; a \u escape that expands to two or three bytes
// writes them together and the extra bytes are absorbed by the queue
// (QUEUE_DEPTH entries, at least three).
module json_string_unescaper_core #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_D
) (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);
  import jsu_pkg::*;

  logic            accept;
  logic            room;
  jsu_push_t       push;
  jsu_dec_status_t dec_status;
  jsu_result_t     head;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  // Parse state and decode of the accepted byte
  jsu_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .op        (in_chan.op),
    .data_byte (in_chan.data_byte),
    .push      (push),
    .status    (dec_status)
  );

  // Results wait here until the sink takes them
  jsu_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (accept),
    .push       (push),
    .room       (room),
    .head_valid (out_chan.valid),
    .head_ready (out_chan.ready),
    .head       (head)
  );

  assign out_chan.kind        = head.kind;
  assign out_chan.out_byte    = head.out_byte;
  assign out_chan.error_code  = head.error_code;
  assign out_chan.last_of_run = head.last_of_run;

  // End of text always returns the parser to waiting for a quote
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.op == OP_END |=> dec_status.phase == PH_IDLE)
    else $error("parser not idle after end of text");

  // The final result written for an item carries the last flag
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept && push.n != 2'd0 |-> push.res[push.n - 2'd1].last_of_run)
    else $error("last result of item not flagged");

  // Only the unicode escape yields more than one result
  a_multi_hex: assert property (@(posedge clk) disable iff (!rst_n)
    accept && push.n > 2'd1 |-> dec_status.phase == PH_HEX)
    else $error("multi-result item outside hex escape");

  // No undefined kind ever reaches the sink
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.kind != 2'd3)
    else $error("undefined result kind offered");

endmodule
`default_nettype wire
